// ===== rtl/cti_pkg.sv =====
// Shared types and constants of the cubic trajectory interpolator.
`default_nettype none
package cti_pkg;

	// command codes carried in s_tuser
	localparam logic [1:0] CMD_FEEDBACK = 2'd0;
	localparam logic [1:0] CMD_MOVE     = 2'd1;
	localparam logic [1:0] CMD_TICK     = 2'd2;

	// result kinds carried in m_tuser
	localparam logic KIND_ACK    = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	// configuration register indexes
	localparam int REG_DEFAULT_X = 0;
	localparam int REG_DEFAULT_Y = 1;
	localparam int REG_DEFAULT_Z = 2;
	localparam int REG_COUNT     = 3;

	// normalized time tau = t/T in Q0.16, position blend in Q0.30, velocity blend in Q1.30
	localparam int TAU_BITS  = 16;
	localparam int FRAC_BITS = 30;
	localparam int S_WIDTH   = 30;
	localparam int W_WIDTH   = 31;
	localparam int S_SHIFT   = 3 * TAU_BITS - FRAC_BITS;

	typedef struct packed {
		logic [S_WIDTH-1:0] s30;  // position blend 3tau^2 - 2tau^3
		logic [W_WIDTH-1:0] w30;  // velocity blend 6tau - 6tau^2
	} tau_t;

endpackage
`default_nettype wire

// ===== rtl/cti_tau.sv =====
// Normalized time divider and cubic blend factor evaluation.
`default_nettype none
module cti_tau #(
	parameter int TIME_WIDTH = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [TIME_WIDTH-1:0] elapsed,
	input  wire logic [TIME_WIDTH-1:0] duration,
	output logic                       done,
	output cti_pkg::tau_t              tau
);

	localparam int TB = cti_pkg::TAU_BITS;
	localparam int CW = $clog2(TB);

	localparam logic [2:0] TS_IDLE = 3'd0;
	localparam logic [2:0] TS_DIV  = 3'd1;
	localparam logic [2:0] TS_SQ   = 3'd2;
	localparam logic [2:0] TS_CUBE = 3'd3;
	localparam logic [2:0] TS_POLY = 3'd4;

	logic [2:0]            state_q;
	logic [CW-1:0]         cnt_q;
	logic                  done_q;
	logic [TIME_WIDTH-1:0] rem_q;
	logic [TB-1:0]         tq_q;
	logic [2*TB-1:0]       tau2_q;
	logic [3*TB-1:0]       tau3_q;
	logic [2*TB:0]         pw_q;
	cti_pkg::tau_t         tau_q;

	logic [TIME_WIDTH:0]   r2;
	logic [TIME_WIDTH:0]   diff;
	logic                  fit;
	logic [TB:0]           omt;
	logic [3*TB+1:0]       s_full;
	logic [2*TB+2:0]       w_full;

	assign r2   = {rem_q, 1'b0};
	assign diff = r2 - {1'b0, duration};
	assign fit  = r2 >= {1'b0, duration};
	assign omt  = {1'b1, {TB{1'b0}}} - {1'b0, tq_q};

	// 3*tau2<<16 - 2*tau3 in Q0.48
	assign s_full = {1'b0, tau2_q, {(TB+1){1'b0}}} + {2'b00, tau2_q, {TB{1'b0}}}
		- {1'b0, tau3_q, 1'b0};
	assign w_full = {pw_q, 2'b00} + {1'b0, pw_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TS_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				TS_IDLE: begin
					if (start) begin
						state_q <= TS_DIV;
						cnt_q   <= CW'(TB - 1);
					end
				end
				TS_DIV: begin
					if (cnt_q == '0) state_q <= TS_SQ;
					cnt_q <= cnt_q - 1'b1;
				end
				TS_SQ:   state_q <= TS_CUBE;
				TS_CUBE: state_q <= TS_POLY;
				TS_POLY: begin
					state_q <= TS_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= TS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			TS_IDLE: begin
				rem_q <= elapsed;
				tq_q  <= '0;
			end
			TS_DIV: begin
				rem_q <= fit ? diff[TIME_WIDTH-1:0] : r2[TIME_WIDTH-1:0];
				tq_q  <= {tq_q[TB-2:0], fit};
			end
			TS_SQ: begin
				tau2_q <= tq_q * tq_q;
				pw_q   <= tq_q * omt;
			end
			TS_CUBE: tau3_q <= tau2_q * tq_q;
			TS_POLY: begin
				tau_q.s30 <= s_full[cti_pkg::S_SHIFT+cti_pkg::S_WIDTH-1:cti_pkg::S_SHIFT];
				tau_q.w30 <= w_full[cti_pkg::W_WIDTH+1:2];
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign tau  = tau_q;

endmodule
`default_nettype wire

// ===== rtl/cti_lane.sv =====
// One axis lane: position step, velocity divide and saturation.
`default_nettype none
module cti_lane #(
	parameter int POS_WIDTH  = 32,
	parameter int TIME_WIDTH = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic signed [POS_WIDTH-1:0] target,
	input  wire logic signed [POS_WIDTH-1:0] origin,
	input  wire cti_pkg::tau_t               tau,
	input  wire logic [TIME_WIDTH-1:0]       duration,
	output logic                             done,
	output logic signed [POS_WIDTH-1:0]      ref_pos,
	output logic signed [POS_WIDTH-1:0]      vel
);

	localparam int P   = POS_WIDTH;
	localparam int HW  = (P + 1) / 2;
	localparam int FW  = cti_pkg::W_WIDTH;
	localparam int FB  = cti_pkg::FRAC_BITS;
	localparam int PPW = HW + FW;
	localparam int ACW = P + FW;
	localparam int NW  = P + 1;
	localparam int CW  = $clog2(NW);

	localparam logic [2:0] LS_IDLE = 3'd0;
	localparam logic [2:0] LS_MUL  = 3'd1;
	localparam logic [2:0] LS_LOAD = 3'd2;
	localparam logic [2:0] LS_DIV  = 3'd3;
	localparam logic [2:0] LS_FIN  = 3'd4;

	localparam logic [2:0] MUL_LAST = 3'd4;

	logic [2:0]            state_q;
	logic [2:0]            mph_q;
	logic [CW-1:0]         cnt_q;
	logic                  done_q;
	logic                  neg_q;
	logic [P-1:0]          mag_q;
	logic [PPW-1:0]        pp_q;
	logic [ACW-1:0]        acc_s_q;
	logic [ACW-1:0]        acc_w_q;
	logic [P-1:0]          step_q;
	logic [NW-1:0]         num_q;
	logic [TIME_WIDTH-1:0] rem_q;
	logic [P-1:0]          ref_q;
	logic [P-1:0]          vel_q;

	logic [P:0]            d;
	logic [P:0]            magw;
	logic [HW-1:0]         op_a;
	logic [FW-1:0]         op_b;
	logic [TIME_WIDTH:0]   r2;
	logic [TIME_WIDTH:0]   diff;
	logic                  fit;
	logic signed [P+1:0]   step_ext;
	logic signed [P+1:0]   ref_full;
	logic signed [P+1:0]   vel_ext;
	logic signed [P+1:0]   vel_full;
	logic                  ref_fits;
	logic                  vel_fits;
	logic [P-1:0]          pos_max;
	logic [P-1:0]          pos_min;

	assign d    = {target[P-1], target} - {origin[P-1], origin};
	assign magw = d[P] ? -d : d;

	always_comb begin
		unique case (mph_q)
			3'd0: begin
				op_a = mag_q[HW-1:0];
				op_b = FW'(tau.s30);
			end
			3'd1: begin
				op_a = HW'(mag_q >> HW);
				op_b = FW'(tau.s30);
			end
			3'd2: begin
				op_a = mag_q[HW-1:0];
				op_b = tau.w30;
			end
			3'd3: begin
				op_a = HW'(mag_q >> HW);
				op_b = tau.w30;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign r2   = {rem_q, num_q[NW-1]};
	assign diff = r2 - {1'b0, duration};
	assign fit  = r2 >= {1'b0, duration};

	assign step_ext = $signed({2'b00, step_q});
	assign ref_full = {{2{origin[P-1]}}, origin} + (neg_q ? -step_ext : step_ext);
	assign vel_ext  = $signed({1'b0, num_q});
	assign vel_full = neg_q ? -vel_ext : vel_ext;

	assign ref_fits = (&ref_full[P+1:P-1]) | ~(|ref_full[P+1:P-1]);
	assign vel_fits = (&vel_full[P+1:P-1]) | ~(|vel_full[P+1:P-1]);
	assign pos_max  = {1'b0, {(P-1){1'b1}}};
	assign pos_min  = {1'b1, {(P-1){1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LS_IDLE;
			mph_q   <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				LS_IDLE: begin
					if (start) begin
						state_q <= LS_MUL;
						mph_q   <= '0;
					end
				end
				LS_MUL: begin
					if (mph_q == MUL_LAST) state_q <= LS_LOAD;
					mph_q <= mph_q + 1'b1;
				end
				LS_LOAD: begin
					state_q <= LS_DIV;
					cnt_q   <= CW'(NW - 1);
				end
				LS_DIV: begin
					if (cnt_q == '0) state_q <= LS_FIN;
					cnt_q <= cnt_q - 1'b1;
				end
				LS_FIN: begin
					state_q <= LS_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= LS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			LS_IDLE: begin
				neg_q <= d[P];
				mag_q <= magw[P-1:0];
			end
			LS_MUL: begin
				pp_q <= op_a * op_b;
				// accumulate the product issued one phase earlier
				unique case (mph_q)
					3'd1: acc_s_q <= ACW'(pp_q);
					3'd2: acc_s_q <= acc_s_q + (ACW'(pp_q) << HW);
					3'd3: acc_w_q <= ACW'(pp_q);
					3'd4: acc_w_q <= acc_w_q + (ACW'(pp_q) << HW);
					default: ;
				endcase
			end
			LS_LOAD: begin
				step_q <= acc_s_q[FB+P-1:FB];
				num_q  <= acc_w_q[ACW-1:FB];
				rem_q  <= '0;
			end
			LS_DIV: begin
				rem_q <= fit ? diff[TIME_WIDTH-1:0] : r2[TIME_WIDTH-1:0];
				num_q <= {num_q[NW-2:0], fit};
			end
			LS_FIN: begin
				ref_q <= ref_fits ? ref_full[P-1:0] : (ref_full[P+1] ? pos_min : pos_max);
				vel_q <= vel_fits ? vel_full[P-1:0] : (vel_full[P+1] ? pos_min : pos_max);
			end
			default: ;
		endcase
	end

	assign done    = done_q;
	assign ref_pos = ref_q;
	assign vel     = vel_q;

endmodule
`default_nettype wire

// ===== rtl/cubic_trajectory_interpolator.sv =====
// Top level of the three-axis cubic trajectory interpolator.
// Input beats on s_*: s_tuser selects feedback, move request or tick; s_tdata carries
// the three positions and the move duration. Result beats on m_*: m_tuser tells a move
// acknowledgement from a reference sample; m_tdata carries the flags and the six
// position and velocity words. Feedback beats and end-of-move ticks give no result.
// One item is worked on at a time; s_tready is high while the block is idle, also
// while a result still waits in the output register.
// Feedback and move requests end in the decode state, where a move request waits
// for a free output register. A tick of an active move runs a 16-step divide for
// tau, three multiply stages, then in each axis lane four partial products and a
// (POS_WIDTH+1)-step velocity divide; the lanes run side by side on x, y and z.
// A stalled receiver holds the output register; a new result waits for it to drain.
// Reset clears the defaults, start point, target and move state; no clearing pass.
// The APB port writes default_x/y/z at byte offsets 0, 4, 8 (8-byte stride above
// 32-bit positions); a write also loads that axis of the target at once.
`default_nettype none
module cubic_trajectory_interpolator #(
	parameter int POS_WIDTH  = 32,
	parameter int TIME_WIDTH = 16,
	localparam int DW  = (POS_WIDTH > 32) ? 64 : 32,
	localparam int ASH = (POS_WIDTH > 32) ? 3 : 2,
	localparam int PAW = ASH + 2,
	localparam int IDW = ((3 * POS_WIDTH + TIME_WIDTH + 7) / 8) * 8,
	localparam int ODW = ((6 * POS_WIDTH + 2 + 7) / 8) * 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [PAW-1:0]      paddr,
	input  wire logic [DW-1:0]       pwdata,
	output logic [DW-1:0]            prdata,
	output logic                     pready,
	// input beats
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [IDW-1:0]      s_tdata,   // in_x, in_y, in_z, duration_ticks
	input  wire logic [1:0]          s_tuser,   // command
	// result beats
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [ODW-1:0]           m_tdata,   // accepted, ref_x, ref_y, ref_z,
	                                            // vel_x, vel_y, vel_z, moving
	output logic                     m_tuser    // result_kind
);

	localparam int P   = POS_WIDTH;
	localparam int NA  = cti_pkg::REG_COUNT;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_TAU    = 3'd2;
	localparam logic [2:0] ST_LANE   = 3'd3;
	localparam logic [2:0] ST_OUT    = 3'd4;

	logic [2:0]            state_q;
	logic signed [P-1:0]   dflt_q   [NA];
	logic signed [P-1:0]   target_q [NA];
	logic signed [P-1:0]   start_q  [NA];
	logic [TIME_WIDTH-1:0] elapsed_q;
	logic [TIME_WIDTH-1:0] duration_q;
	logic                  active_q;
	logic                  locked_q;

	logic [1:0]            cmd_q;
	logic signed [P-1:0]   pos_q [NA];
	logic [TIME_WIDTH-1:0] dur_q;

	logic                  tau_start_q;
	logic                  lane_start_q;
	logic                  m_valid_q;
	logic                  out_kind_q;
	logic                  out_acc_q;
	logic                  out_moving_q;
	logic [P-1:0]          out_ref_q [NA];
	logic [P-1:0]          out_vel_q [NA];

	logic                  tau_done;
	cti_pkg::tau_t         tau;
	logic [NA-1:0]         lane_done;
	logic signed [P-1:0]   lane_ref [NA];
	logic signed [P-1:0]   lane_vel [NA];

	logic                  in_beat;
	logic                  cfg_we;
	logic [1:0]            cfg_idx;
	logic                  out_free;
	logic                  move_ok;

	assign in_beat  = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign cfg_we   = psel && penable && pwrite;
	assign cfg_idx  = paddr[PAW-1:ASH];
	assign out_free = !m_valid_q || m_tready;
	assign move_ok  = pos_q[2] > 0;
	assign pready   = 1'b1;
	assign prdata   = (int'(cfg_idx) < NA) ? DW'(dflt_q[cfg_idx]) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			elapsed_q    <= '0;
			duration_q   <= '0;
			active_q     <= 1'b0;
			locked_q     <= 1'b0;
			tau_start_q  <= 1'b0;
			lane_start_q <= 1'b0;
			m_valid_q    <= 1'b0;
			for (int i = 0; i < NA; i++) begin
				dflt_q[i]   <= '0;
				target_q[i] <= '0;
				start_q[i]  <= '0;
			end
		end else begin
			tau_start_q  <= 1'b0;
			lane_start_q <= 1'b0;
			if (m_valid_q && m_tready) m_valid_q <= 1'b0;

			if (cfg_we && int'(cfg_idx) < NA) begin
				dflt_q[cfg_idx]   <= pwdata[P-1:0];
				target_q[cfg_idx] <= pwdata[P-1:0];
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					unique case (cmd_q)
						cti_pkg::CMD_FEEDBACK: begin
							if (!locked_q) begin
								for (int i = 0; i < NA; i++) start_q[i] <= pos_q[i];
							end
							state_q <= ST_IDLE;
						end
						cti_pkg::CMD_MOVE: begin
							// hold until the output register can take the ack
							if (out_free) begin
								if (move_ok) begin
									for (int i = 0; i < NA; i++) target_q[i] <= pos_q[i];
									duration_q <= dur_q;
									elapsed_q  <= '0;
									active_q   <= 1'b1;
								end
								m_valid_q <= 1'b1;
								state_q   <= ST_IDLE;
							end
						end
						cti_pkg::CMD_TICK: begin
							if (!active_q) begin
								if (out_free) begin
									m_valid_q <= 1'b1;
									state_q   <= ST_IDLE;
								end
							end else if (elapsed_q >= duration_q) begin
								active_q <= 1'b0;
								locked_q <= 1'b0;
								state_q  <= ST_IDLE;
							end else begin
								tau_start_q <= 1'b1;
								state_q     <= ST_TAU;
							end
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_TAU: begin
					if (tau_done) begin
						lane_start_q <= 1'b1;
						state_q      <= ST_LANE;
					end
				end
				ST_LANE: begin
					if (&lane_done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						elapsed_q <= elapsed_q + 1'b1;
						locked_q  <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item capture and result payload
	always_ff @(posedge clk) begin
		if (in_beat) begin
			cmd_q    <= s_tuser;
			pos_q[0] <= s_tdata[P-1:0];
			pos_q[1] <= s_tdata[2*P-1:P];
			pos_q[2] <= s_tdata[3*P-1:2*P];
			dur_q    <= s_tdata[3*P+TIME_WIDTH-1:3*P];
		end
		if (state_q == ST_DECODE && out_free) begin
			if (cmd_q == cti_pkg::CMD_MOVE) begin
				out_kind_q   <= cti_pkg::KIND_ACK;
				out_acc_q    <= move_ok;
				out_moving_q <= move_ok || active_q;
				for (int i = 0; i < NA; i++) begin
					out_ref_q[i] <= move_ok ? pos_q[i] : target_q[i];
					out_vel_q[i] <= '0;
				end
			end else if (cmd_q == cti_pkg::CMD_TICK && !active_q) begin
				out_kind_q   <= cti_pkg::KIND_SAMPLE;
				out_acc_q    <= 1'b0;
				out_moving_q <= 1'b0;
				for (int i = 0; i < NA; i++) begin
					out_ref_q[i] <= target_q[i];
					out_vel_q[i] <= '0;
				end
			end
		end else if (state_q == ST_OUT && out_free) begin
			// merge the lane results into one sample beat
			out_kind_q   <= cti_pkg::KIND_SAMPLE;
			out_acc_q    <= 1'b0;
			out_moving_q <= 1'b1;
			for (int i = 0; i < NA; i++) begin
				out_ref_q[i] <= lane_ref[i];
				out_vel_q[i] <= lane_vel[i];
			end
		end
	end

	cti_tau #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_tau (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (tau_start_q),
		.elapsed  (elapsed_q),
		.duration (duration_q),
		.done     (tau_done),
		.tau      (tau)
	);

	for (genvar g = 0; g < NA; g++) begin : g_lane
		cti_lane #(
			.POS_WIDTH (POS_WIDTH),
			.TIME_WIDTH(TIME_WIDTH)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (lane_start_q),
			.target   (target_q[g]),
			.origin   (start_q[g]),
			.tau      (tau),
			.duration (duration_q),
			.done     (lane_done[g]),
			.ref_pos  (lane_ref[g]),
			.vel      (lane_vel[g])
		);
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = ODW'({out_moving_q, out_vel_q[2], out_vel_q[1], out_vel_q[0],
		out_ref_q[2], out_ref_q[1], out_ref_q[0], out_acc_q});

endmodule
`default_nettype wire
